// ===== hdl/pli_pkg.sv =====
// shared types, constants and elaboration helpers for the positional list
`timescale 1ns / 1ps
package pli_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int POS_W          = 7;
  localparam int WORD_W         = 32;
  localparam int CNT_OUT_W      = 7;
  localparam int FAN_IN         = 8;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_HOLD
  } ctl_state_t;

  typedef struct packed {
    req_kind_t                 req_type;
    logic [POS_W-1:0]          position;
    logic signed [WORD_W-1:0]  value;
  } req_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [WORD_W-1:0]  removed_value;
    logic [CNT_OUT_W-1:0]      entries_held;
  } rsp_item_t;

  // broadcast to every cell; ins and del are only set for accepted requests
  typedef struct packed {
    logic             load;
    logic             ins;
    logic             del;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

  // number of registered 8-way levels needed to reduce n leaves to one
  function automatic int tree_levels(input int n);
    int lv;
    int span;
    lv   = 0;
    span = 1;
    while (span < n) begin
      span = span * FAN_IN;
      lv   = lv + 1;
    end
    return lv;
  endfunction

  // node count at level lv of the reduction tree over n leaves
  function automatic int nodes_at(input int n, input int lv);
    int cnt;
    cnt = n;
    for (int i = 0; i < lv; i++) begin
      cnt = (cnt + FAN_IN - 1) / FAN_IN;
    end
    return cnt;
  endfunction

endpackage

// ===== hdl/pli_cell.sv =====
// one list slot: holds a word, shifts from either neighbor, taps out on delete
`timescale 1ns / 1ps
module pli_cell import pli_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX_W      = POS_W,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] tap
);

  localparam logic [IDX_W-1:0] ME      = IDX_W'(IDX);
  localparam logic [IDX_W-1:0] ME_NEXT = IDX_W'(IDX + 1);

  logic [IDX_W-1:0] pos_x;

  assign pos_x = IDX_W'(cmd.pos);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (ME > pos_x) begin
        word <= left;
      end else if (ME == pos_x) begin
        word <= value;
      end
    end else if (cmd.del) begin
      // element pos-1 and everything above it pull from the right
      if (ME_NEXT >= pos_x) begin
        word <= right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tap <= (cmd.del && ME_NEXT == pos_x) ? word : '0;
    end
  end

endmodule

// ===== hdl/pli_or_tree.sv =====
// registered 8-way or-reduction tree that collects the single nonzero tap
`timescale 1ns / 1ps
module pli_or_tree import pli_pkg::*; #(
  parameter int WIDTH  = DATA_WIDTH_DEF,
  parameter int LEAVES = DEPTH_DEF
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] leaf [LEAVES],
  output logic [WIDTH-1:0] root
);

  localparam int LEVELS = tree_levels(LEAVES);
  localparam int NMAX   = nodes_at(LEAVES, 1);

  logic [WIDTH-1:0] node [1:LEVELS][NMAX];

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int N_PREV = nodes_at(LEAVES, l - 1);
    localparam int N_HERE = nodes_at(LEAVES, l);
    for (genvar j = 0; j < N_HERE; j++) begin : g_node
      logic [WIDTH-1:0] part [FAN_IN];
      logic [WIDTH-1:0] acc;
      for (genvar k = 0; k < FAN_IN; k++) begin : g_in
        if (j * FAN_IN + k >= N_PREV) begin : g_pad
          assign part[k] = '0;
        end else if (l == 1) begin : g_leaf
          assign part[k] = leaf[j * FAN_IN + k];
        end else begin : g_inner
          assign part[k] = node[l-1][j * FAN_IN + k];
        end
      end
      always_comb begin
        acc = '0;
        for (int k = 0; k < FAN_IN; k++) begin
          acc = acc | part[k];
        end
      end
      always_ff @(posedge clk) begin
        node[l][j] <= acc;
      end
    end
  end

  assign root = node[LEVELS][0];

endmodule

// ===== hdl/positional_list_insert_delete.sv =====
// top level: positional insert/delete list built from a row of shifting cells
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req_item_t (req_type, position, value)
//  rsp     | out       | rsp_valid, rsp_stall | rsp_item_t (status, removed_value, entries_held)
//
// one item at a time: the cells shift on the accept edge and the removed word
// climbs an 8-way registered or-tree of L = ceil(log8(DEPTH)) levels (2 at 64).
// result shows once the word has climbed all L levels, next item is taken the cycle
// after it leaves; rsp holds while rsp_stall is high.
// rst clears the element count and the control and holds req_stall high.
// cell contents are not reset; req_stall stays high until the result is taken.
`timescale 1ns / 1ps
module positional_list_insert_delete import pli_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int IW     = (CW > POS_W) ? CW : POS_W;
  localparam int LEVELS = tree_levels(DEPTH);
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  ctl_state_t state, state_next;
  logic [LW-1:0] lvl;
  logic [CW-1:0] cnt;
  status_t       status_r;

  logic            accept;
  logic [IW-1:0]   pos_x;
  logic [IW-1:0]   cnt_x;
  logic            is_ins;
  logic            bad_pos;
  logic            full;
  status_t         status_next;
  logic            ok;
  cell_cmd_t       cmd;

  logic [DATA_WIDTH-1:0] value_w;
  logic [DATA_WIDTH-1:0] words [DEPTH];
  logic [DATA_WIDTH-1:0] taps  [DEPTH];
  logic [DATA_WIDTH-1:0] root;

  assign accept = req_valid && !req_stall;
  assign pos_x  = IW'(req.position);
  assign cnt_x  = IW'(cnt);
  assign is_ins = (req.req_type == REQ_INSERT);
  assign full   = (cnt == CW'(DEPTH));

  always_comb begin
    if (is_ins) begin
      bad_pos = (pos_x > cnt_x);
    end else begin
      bad_pos = (pos_x == '0) || (pos_x > cnt_x);
    end
    if (bad_pos) begin
      status_next = STAT_BAD_POS;
    end else if (is_ins && full) begin
      status_next = STAT_FULL;
    end else begin
      status_next = STAT_DONE;
    end
  end

  assign ok = (status_next == STAT_DONE);

  always_comb begin
    cmd.load = accept;
    cmd.ins  = accept && ok && is_ins;
    cmd.del  = accept && ok && !is_ins;
    cmd.pos  = req.position;
  end

  // stored form is the low bits of the sign-extended word
  assign value_w = DATA_WIDTH'(req.value);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    pli_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IW),
      .IDX        (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .value (value_w),
      .left  (left_w),
      .right (right_w),
      .word  (words[i]),
      .tap   (taps[i])
    );
  end

  pli_or_tree #(
    .WIDTH  (DATA_WIDTH),
    .LEAVES (DEPTH)
  ) u_tree (
    .clk  (clk),
    .leaf (taps),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.ins) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.del) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl   <= '0;
    end else begin
      state <= state_next;
      if (state == S_WAIT) begin
        lvl <= lvl + 1'b1;
      end else begin
        lvl <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (lvl == LW'(LEVELS - 1)) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall = rst || (state != S_IDLE);
    rsp_valid = (state == S_HOLD);
  end

  always_comb begin
    rsp.status        = status_r;
    rsp.removed_value = WORD_W'(root);
    rsp.entries_held  = CNT_OUT_W'(cnt);
  end

endmodule

// ===== hdl/pli_checker.sv =====
// port-level checks for the positional list, bound to the top level
`timescale 1ns / 1ps
module pli_checker import pli_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_item_t rsp
);

  // only one item in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item accepted while another is in flight");

  a_no_take_while_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("input open while a result waits");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STAT_DONE |-> rsp.removed_value == '0)
    else $error("rejected item returned a nonzero word");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STAT_FULL |-> rsp.entries_held == CNT_OUT_W'(DEPTH))
    else $error("full status without a full list");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

endmodule

bind positional_list_insert_delete pli_checker #(.DEPTH(DEPTH)) u_pli_checker (.*);
